[rtl/core/b58d_pkg.sv]
// Shared types, constants and the alphabet lookup of the Base58 decoder.
`default_nettype none

package b58d_pkg;

   // Capacity of the number in bytes, one cell per byte
   localparam int MAX_BYTES = 64;

   localparam int BYTE_W  = 8;
   localparam int DIGIT_W = 6;
   // Pending carry between cells never exceeds 74 with a radix of 58
   localparam int CARRY_W = 7;
   localparam int SUM_W   = BYTE_W + 1;
   localparam int PROD_W  = BYTE_W + CARRY_W;
   localparam int RADIX   = 58;

   // Byte count 0..MAX_BYTES
   localparam int COUNT_W = $clog2(MAX_BYTES + 1);
   // Leading-one counter saturates at 127
   localparam int LEAD_W   = 7;
   localparam int TOTAL_W  = ((LEAD_W > COUNT_W) ? LEAD_W : COUNT_W) + 1;

   localparam logic [BYTE_W-1:0] CHAR_ONE = 8'h31;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_INVALID  = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   typedef enum logic [2:0] {
      ST_ACCUM,
      ST_FLUSH,
      ST_ALIGN,
      ST_EMIT,
      ST_ERROR
   } state_type;

   typedef enum logic [1:0] {
      CELL_STEP,
      CELL_SHIFT,
      CELL_CLEAR
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        mul_en;
   } cell_ctl_type;

   typedef struct packed {
      logic               valid;
      logic [DIGIT_W-1:0] value;
   } digit_type;

   // Maps an ASCII code to its Base58 digit; valid low outside the alphabet
   function automatic digit_type digit_of(input logic [BYTE_W-1:0] code);
      digit_type   d;
      logic [BYTE_W-1:0] diff;
      d    = '0;
      diff = '0;
      unique if (code >= 8'h31 && code <= 8'h39) begin
         diff = code - 8'h31;
         d.valid = 1'b1;
      end else if (code >= 8'h41 && code <= 8'h48) begin
         diff = code - 8'h41 + 8'd9;
         d.valid = 1'b1;
      end else if (code >= 8'h4A && code <= 8'h4E) begin
         diff = code - 8'h4A + 8'd17;
         d.valid = 1'b1;
      end else if (code >= 8'h50 && code <= 8'h5A) begin
         diff = code - 8'h50 + 8'd22;
         d.valid = 1'b1;
      end else if (code >= 8'h61 && code <= 8'h6B) begin
         diff = code - 8'h61 + 8'd33;
         d.valid = 1'b1;
      end else if (code >= 8'h6D && code <= 8'h7A) begin
         diff = code - 8'h6D + 8'd44;
         d.valid = 1'b1;
      end else begin
         diff = '0;
         d.valid = 1'b0;
      end
      d.value = diff[DIGIT_W-1:0];
      return d;
   endfunction

endpackage

`default_nettype wire

[rtl/core/b58d_cell.sv]
// One byte cell of the number chain: byte value plus pending carry to the next cell.
`default_nettype none

module b58d_cell (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire b58d_pkg::cell_ctl_type          ctl,
   input  wire logic [b58d_pkg::DIGIT_W-1:0]    add_in,
   input  wire logic [b58d_pkg::CARRY_W-1:0]    carry_in,
   input  wire logic [b58d_pkg::BYTE_W-1:0]     byte_in,
   output logic      [b58d_pkg::BYTE_W-1:0]     byte_out,
   output logic      [b58d_pkg::CARRY_W-1:0]    carry_out
);

   logic [b58d_pkg::BYTE_W-1:0]  value_ff,  value_in;
   logic [b58d_pkg::CARRY_W-1:0] carry_ff,  carry_next_in;
   logic [b58d_pkg::SUM_W-1:0]   sum;
   logic [b58d_pkg::PROD_W-1:0]  prod;
   logic [b58d_pkg::PROD_W-1:0]  total;

   // (value + carry from below) * 58 + digit, or just the carry resolve
   assign sum   = {1'b0, value_ff} + b58d_pkg::SUM_W'(carry_in);
   assign prod  = ctl.mul_en ? b58d_pkg::PROD_W'(sum) * b58d_pkg::PROD_W'(b58d_pkg::RADIX)
                             : b58d_pkg::PROD_W'(sum);
   assign total = prod + (ctl.mul_en ? b58d_pkg::PROD_W'(add_in) : '0);

   always_comb begin
      value_in      = value_ff;
      carry_next_in = carry_ff;
      unique case (ctl.op)
         b58d_pkg::CELL_STEP: begin
            value_in      = total[b58d_pkg::BYTE_W-1:0];
            carry_next_in = total[b58d_pkg::PROD_W-1:b58d_pkg::BYTE_W];
         end
         b58d_pkg::CELL_SHIFT: begin
            value_in      = byte_in;
            carry_next_in = '0;
         end
         b58d_pkg::CELL_CLEAR: begin
            value_in      = '0;
            carry_next_in = '0;
         end
         default: begin
            value_in      = value_ff;
            carry_next_in = carry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
         carry_ff <= '0;
      end else begin
         value_ff <= value_in;
         carry_ff <= carry_next_in;
      end
   end

   assign byte_out  = value_ff;
   assign carry_out = carry_ff;

endmodule

`default_nettype wire

[rtl/core/b58d_chain.sv]
// Row of byte cells holding the number in carry-save form, least significant cell first.
`default_nettype none

module b58d_chain (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire b58d_pkg::cell_ctl_type          ctl,
   input  wire logic [b58d_pkg::DIGIT_W-1:0]    digit,
   output logic      [b58d_pkg::BYTE_W-1:0]     top_byte,
   output logic                                 top_carry_nz,
   output logic                                 carry_any
);

   logic [b58d_pkg::BYTE_W-1:0]  byte_w  [b58d_pkg::MAX_BYTES];
   logic [b58d_pkg::CARRY_W-1:0] carry_w [b58d_pkg::MAX_BYTES];
   logic [b58d_pkg::MAX_BYTES-1:0] carry_nz;

   for (genvar j = 0; j < b58d_pkg::MAX_BYTES; j++) begin : g_cell
      if (j == 0) begin : g_low
         b58d_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctl       (ctl),
            .add_in    (digit),
            .carry_in  ('0),
            .byte_in   ('0),
            .byte_out  (byte_w[j]),
            .carry_out (carry_w[j])
         );
      end else begin : g_upper
         b58d_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctl       (ctl),
            .add_in    ('0),
            .carry_in  (carry_w[j-1]),
            .byte_in   (byte_w[j-1]),
            .byte_out  (byte_w[j]),
            .carry_out (carry_w[j])
         );
      end
      assign carry_nz[j] = |carry_w[j];
   end

   assign top_byte     = byte_w[b58d_pkg::MAX_BYTES-1];
   // Carry out of the top cell means the number no longer fits
   assign top_carry_nz = carry_nz[b58d_pkg::MAX_BYTES-1];
   assign carry_any    = |carry_nz;

endmodule

`default_nettype wire

[rtl/core/base58_decoder_unit.sv]
// Base58 decoder top level: control sequencer, flags and result register.
// ---------------------------------------------------------------------------
// Streaming Base58 decoder for the 58-symbol alphabet that omits 0, O, I and
// l. One character is taken per transaction on the req_ channel, with
// req_last_char marking the end of a string; non-final characters give no
// result. The number lives in a row of MAX_BYTES byte cells in carry-save
// form, so all cells take in each accepted character (multiply by 58, add
// digit) in parallel and characters may arrive back to back. After the last
// character the pending carries ripple up the row, one cell per cycle, then
// the row shifts up past any high zero bytes to find the byte count. Results
// follow at one per cycle while rsp_ready stays high: one zero byte per
// leading '1', then the number's bytes, most significant first, with
// rsp_last_byte on the final one. An invalid character anywhere gives a
// single result with status invalid straight after the last character; a
// number or output longer than MAX_BYTES gives a single overflow result.
// Invalid wins over overflow; error results carry data 0. The next string is
// accepted once the final result sits in the output register. No clearing
// pass is needed after reset.
// ---------------------------------------------------------------------------
`default_nettype none

module base58_decoder_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [7:0]                      req_char_code,
   input  wire logic                            req_last_char,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic      [7:0]                      rsp_data_byte,
   output logic                                 rsp_last_byte,
   output logic      [1:0]                      rsp_status
);

   b58d_pkg::state_type state_ff, state_in;

   // String flags and counters
   logic [b58d_pkg::LEAD_W-1:0]  lead_ff, lead_in;   // leading '1's, later zeros left
   logic                         run_ff,  run_in;    // still in the leading run
   logic                         bad_ff,  bad_in;
   logic                         ovf_ff,  ovf_in;
   logic [b58d_pkg::COUNT_W-1:0] bc_ff,   bc_in;     // number bytes (left)

   // Output register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff,  rsp_data_in;
   logic       rsp_last_ff,  rsp_last_in;
   logic [1:0] rsp_status_ff, rsp_status_in;

   b58d_pkg::cell_ctl_type       cell_ctl;
   b58d_pkg::digit_type          dig;
   logic [b58d_pkg::BYTE_W-1:0]  top_byte;
   logic                         top_carry_nz;
   logic                         carry_any;

   logic                          req_accept;
   logic                          can_load;
   logic                          align_skip;
   logic [b58d_pkg::TOTAL_W-1:0]  total;
   logic                          too_long;

   assign dig        = b58d_pkg::digit_of(req_char_code);
   assign req_ready  = (state_ff == b58d_pkg::ST_ACCUM);
   assign req_accept = req_valid & req_ready;
   // Result register free now or freed by this cycle's handshake
   assign can_load   = ~rsp_valid_ff | rsp_ready;
   assign align_skip = (bc_ff != '0) && (top_byte == '0);
   // Results still owed: remaining zeros plus remaining number bytes
   assign total      = b58d_pkg::TOTAL_W'(lead_ff) + b58d_pkg::TOTAL_W'(bc_ff);
   assign too_long   = total > b58d_pkg::TOTAL_W'(b58d_pkg::MAX_BYTES);

   b58d_chain u_chain (
      .clock        (clock),
      .reset        (reset),
      .ctl          (cell_ctl),
      .digit        (dig.value),
      .top_byte     (top_byte),
      .top_carry_nz (top_carry_nz),
      .carry_any    (carry_any)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         b58d_pkg::ST_ACCUM: begin
            if (req_accept && req_last_char) begin
               // An invalid character needs no carry settling
               state_in = (bad_ff || !dig.valid) ? b58d_pkg::ST_ERROR : b58d_pkg::ST_FLUSH;
            end
         end
         b58d_pkg::ST_FLUSH: begin
            if (!carry_any) begin
               state_in = ovf_ff ? b58d_pkg::ST_ERROR : b58d_pkg::ST_ALIGN;
            end
         end
         b58d_pkg::ST_ALIGN: begin
            if (!align_skip) begin
               if (too_long) begin
                  state_in = b58d_pkg::ST_ERROR;
               end else if (total == '0) begin
                  state_in = b58d_pkg::ST_ACCUM;
               end else begin
                  state_in = b58d_pkg::ST_EMIT;
               end
            end
         end
         b58d_pkg::ST_EMIT: begin
            if (can_load && total == b58d_pkg::TOTAL_W'(1)) begin
               state_in = b58d_pkg::ST_ACCUM;
            end
         end
         b58d_pkg::ST_ERROR: begin
            if (can_load) begin
               state_in = b58d_pkg::ST_ACCUM;
            end
         end
         default: state_in = b58d_pkg::ST_ACCUM;
      endcase
   end

   // Datapath control, flags and result register loading
   always_comb begin
      lead_in       = lead_ff;
      run_in        = run_ff;
      bad_in        = bad_ff;
      // Sticky: any carry leaving the top cell is an overflow
      ovf_in        = ovf_ff | top_carry_nz;
      bc_in         = bc_ff;
      cell_ctl.op     = b58d_pkg::CELL_STEP;
      cell_ctl.mul_en = 1'b0;

      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;

      unique case (state_ff)
         b58d_pkg::ST_ACCUM: begin
            if (req_accept) begin
               if (run_ff && req_char_code == b58d_pkg::CHAR_ONE) begin
                  if (lead_ff != '1) begin
                     lead_in = lead_ff + b58d_pkg::LEAD_W'(1);
                  end
               end else begin
                  run_in = 1'b0;
               end
               if (!dig.valid) begin
                  bad_in = 1'b1;
               end
               cell_ctl.mul_en = dig.valid & ~bad_ff & ~ovf_ff;
            end
         end
         b58d_pkg::ST_FLUSH: begin
            // Cells resolve carries; the byte scan starts from full width
            bc_in = b58d_pkg::COUNT_W'(b58d_pkg::MAX_BYTES);
         end
         b58d_pkg::ST_ALIGN: begin
            if (align_skip) begin
               cell_ctl.op = b58d_pkg::CELL_SHIFT;
               bc_in       = bc_ff - b58d_pkg::COUNT_W'(1);
            end else if (too_long) begin
               ovf_in = 1'b1;
            end else if (total == '0) begin
               cell_ctl.op = b58d_pkg::CELL_CLEAR;
               lead_in = '0;
               run_in  = 1'b1;
               bad_in  = 1'b0;
               ovf_in  = 1'b0;
               bc_in   = '0;
            end
         end
         b58d_pkg::ST_EMIT: begin
            if (can_load) begin
               rsp_valid_in  = 1'b1;
               rsp_last_in   = (total == b58d_pkg::TOTAL_W'(1));
               rsp_status_in = b58d_pkg::STATUS_OK;
               if (lead_ff != '0) begin
                  rsp_data_in = '0;
                  lead_in     = lead_ff - b58d_pkg::LEAD_W'(1);
               end else begin
                  rsp_data_in = top_byte;
                  cell_ctl.op = b58d_pkg::CELL_SHIFT;
                  bc_in       = bc_ff - b58d_pkg::COUNT_W'(1);
               end
               if (total == b58d_pkg::TOTAL_W'(1)) begin
                  cell_ctl.op = b58d_pkg::CELL_CLEAR;
                  lead_in = '0;
                  run_in  = 1'b1;
                  bad_in  = 1'b0;
                  ovf_in  = 1'b0;
                  bc_in   = '0;
               end
            end
         end
         b58d_pkg::ST_ERROR: begin
            if (can_load) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = '0;
               rsp_last_in   = 1'b1;
               rsp_status_in = bad_ff ? b58d_pkg::STATUS_INVALID : b58d_pkg::STATUS_OVERFLOW;
               cell_ctl.op   = b58d_pkg::CELL_CLEAR;
               lead_in = '0;
               run_in  = 1'b1;
               bad_in  = 1'b0;
               ovf_in  = 1'b0;
               bc_in   = '0;
            end
         end
         default: begin
            cell_ctl.op = b58d_pkg::CELL_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= b58d_pkg::ST_ACCUM;
         lead_ff      <= '0;
         run_ff       <= 1'b1;
         bad_ff       <= 1'b0;
         ovf_ff       <= 1'b0;
         bc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lead_ff      <= lead_in;
         run_ff       <= run_in;
         bad_ff       <= bad_in;
         ovf_ff       <= ovf_in;
         bc_ff        <= bc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload needs no reset
   always_ff @(posedge clock) begin
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data_byte = rsp_data_ff;
   assign rsp_last_byte = rsp_last_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

`default_nettype wire
